/* rtl/qrs_pkg.sv */
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int DISC_W    = 2 * COEF_W + 2;
    localparam int ROOT_W    = 48;
    localparam int CLASS_W   = 2;

    localparam int SQ_N   = DISC_W / 2 + FRAC_BITS;
    localparam int SQ_RW  = SQ_N + 3;
    localparam int MAG_W  = SQ_N + 1;
    localparam int NUM_W  = MAG_W + 1;
    localparam int DEN_W  = COEF_W + 1;
    localparam int PROD_W = 2 * COEF_W;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [DISC_W-1:0] t_disc;
    typedef logic signed [ROOT_W-1:0] t_root;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE   = 2'd0,
        CLS_DOUBLE = 2'd1,
        CLS_TWO    = 2'd2,
        CLS_DEGEN  = 2'd3
    } t_root_class;

endpackage

/* rtl/qrs_coef_if.sv */
interface qrs_coef_if;
    import qrs_pkg::*;

    logic  valid;
    logic  ready;
    t_coef coef_a;
    t_coef coef_b;
    t_coef coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

/* rtl/qrs_root_if.sv */
interface qrs_root_if;
    import qrs_pkg::*;

    logic        valid;
    logic        ready;
    t_root_class root_class;
    t_disc       discriminant;
    t_root       root_plus;
    t_root       root_minus;

    modport source (output valid, output root_class, output discriminant,
                    output root_plus, output root_minus, input ready);
    modport sink (input valid, input root_class, input discriminant,
                  input root_plus, input root_minus, output ready);
endinterface

/* rtl/quadratic_root_solver_top.sv */
// Throughput: one transaction per cycle while the output is not stalled; the pipeline is 72 register stages long,
// set by one square-root digit per stage (33) and one quotient bit per stage (34).
// The whole pipeline holds while the output register is full and not taken.
// Reset is synchronous, active low, and clears all valid bits.
module quadratic_root_solver_top (
    input logic        i_clk,
    input logic        i_rst_n,
    qrs_coef_if.sink   i_coef,
    qrs_root_if.source o_root
);
    import qrs_pkg::*;

    localparam int SQ0 = 2;
    localparam int DV0 = SQ0 + SQ_N + 1;
    localparam int NST = DV0 + MAG_W + 2;

    logic           r_v [NST];
    logic           en;

    t_coef          r_a0, r_b0, r_c0;
    logic signed [PROD_W-1:0] r_bb, r_ac;
    t_coef          r_a1, r_b1;
    t_disc          n_disc;
    t_root_class    n_cls;

    logic [DISC_W-1:0] r_sq_d    [SQ_N+1];
    logic [SQ_RW-1:0]  r_sq_rem  [SQ_N+1];
    logic [SQ_N-1:0]   r_sq_root [SQ_N+1];
    t_coef             r_sq_a    [SQ_N+1];
    t_coef             r_sq_b    [SQ_N+1];
    t_root_class       r_sq_cls  [SQ_N+1];
    t_disc             r_sq_disc [SQ_N+1];

    logic [MAG_W-1:0]  r_dv_np   [MAG_W+1];
    logic [MAG_W-1:0]  r_dv_nm   [MAG_W+1];
    logic [DEN_W-1:0]  r_dv_rp   [MAG_W+1];
    logic [DEN_W-1:0]  r_dv_rm   [MAG_W+1];
    logic [MAG_W-1:0]  r_dv_qp   [MAG_W+1];
    logic [MAG_W-1:0]  r_dv_qm   [MAG_W+1];
    logic [DEN_W-1:0]  r_dv_den  [MAG_W+1];
    logic              r_dv_sp   [MAG_W+1];
    logic              r_dv_sm   [MAG_W+1];
    t_root_class       r_dv_cls  [MAG_W+1];
    t_disc             r_dv_disc [MAG_W+1];

    logic signed [NUM_W-1:0] n_nb, n_np, n_nm;
    logic [COEF_W:0]         n_am;

    t_root_class r_o_cls;
    t_disc       r_o_disc;
    t_root       r_o_rp, r_o_rm;
    t_root       n_rp, n_rm;

    assign en           = !r_v[NST-1] || o_root.ready;
    assign i_coef.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_coef.valid;
            for (int k = 1; k < NST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        n_disc = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
        if (r_a1 == '0) begin
            n_cls = CLS_DEGEN;
        end else if (n_disc < 0) begin
            n_cls = CLS_NONE;
        end else if (n_disc == '0) begin
            n_cls = CLS_DOUBLE;
        end else begin
            n_cls = CLS_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= i_coef.coef_a;
            r_b0 <= i_coef.coef_b;
            r_c0 <= i_coef.coef_c;
            r_bb <= r_b0 * r_b0;
            r_ac <= r_a0 * r_c0;
            r_a1 <= r_a0;
            r_b1 <= r_b0;
            r_sq_d[0]    <= n_disc;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_a[0]    <= r_a1;
            r_sq_b[0]    <= r_b1;
            r_sq_cls[0]  <= n_cls;
            r_sq_disc[0] <= n_disc;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        localparam int I = SQ_N - 1 - k;
        logic [1:0]       pair;
        logic [SQ_RW-1:0] rem_sh, trial;
        logic             ge;

        if (I >= FRAC_BITS) begin : g_pair
            assign pair = r_sq_d[k][2*(I-FRAC_BITS)+1 -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {r_sq_rem[k][SQ_RW-3:0], pair};
        assign trial  = {1'b0, r_sq_root[k], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[k+1] <= {r_sq_root[k][SQ_N-2:0], ge};
                r_sq_d[k+1]    <= r_sq_d[k];
                r_sq_a[k+1]    <= r_sq_a[k];
                r_sq_b[k+1]    <= r_sq_b[k];
                r_sq_cls[k+1]  <= r_sq_cls[k];
                r_sq_disc[k+1] <= r_sq_disc[k];
            end
        end
    end

    always_comb begin
        n_nb = -(NUM_W'(r_sq_b[SQ_N]) <<< FRAC_BITS);
        n_np = n_nb + $signed(NUM_W'(r_sq_root[SQ_N]));
        n_nm = n_nb - $signed(NUM_W'(r_sq_root[SQ_N]));
        n_am = r_sq_a[SQ_N][COEF_W-1] ? -(COEF_W+1)'(r_sq_a[SQ_N])
                                      : (COEF_W+1)'(r_sq_a[SQ_N]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_np[0]   <= n_np[NUM_W-1] ? MAG_W'(-n_np) : MAG_W'(n_np);
            r_dv_nm[0]   <= n_nm[NUM_W-1] ? MAG_W'(-n_nm) : MAG_W'(n_nm);
            r_dv_rp[0]   <= '0;
            r_dv_rm[0]   <= '0;
            r_dv_qp[0]   <= '0;
            r_dv_qm[0]   <= '0;
            r_dv_den[0]  <= {n_am[COEF_W-1:0], 1'b0};
            r_dv_sp[0]   <= n_np[NUM_W-1] ^ r_sq_a[SQ_N][COEF_W-1];
            r_dv_sm[0]   <= n_nm[NUM_W-1] ^ r_sq_a[SQ_N][COEF_W-1];
            r_dv_cls[0]  <= r_sq_cls[SQ_N];
            r_dv_disc[0] <= r_sq_disc[SQ_N];
        end
    end

    for (genvar j = 0; j < MAG_W; j++) begin : g_dv
        logic [DEN_W:0] tp, tm, dx;
        logic           gp, gm;

        assign dx = {1'b0, r_dv_den[j]};
        assign tp = {r_dv_rp[j], r_dv_np[j][MAG_W-1]};
        assign tm = {r_dv_rm[j], r_dv_nm[j][MAG_W-1]};
        assign gp = tp >= dx;
        assign gm = tm >= dx;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rp[j+1]   <= DEN_W'(gp ? tp - dx : tp);
                r_dv_rm[j+1]   <= DEN_W'(gm ? tm - dx : tm);
                r_dv_np[j+1]   <= {r_dv_np[j][MAG_W-2:0], 1'b0};
                r_dv_nm[j+1]   <= {r_dv_nm[j][MAG_W-2:0], 1'b0};
                r_dv_qp[j+1]   <= {r_dv_qp[j][MAG_W-2:0], gp};
                r_dv_qm[j+1]   <= {r_dv_qm[j][MAG_W-2:0], gm};
                r_dv_den[j+1]  <= r_dv_den[j];
                r_dv_sp[j+1]   <= r_dv_sp[j];
                r_dv_sm[j+1]   <= r_dv_sm[j];
                r_dv_cls[j+1]  <= r_dv_cls[j];
                r_dv_disc[j+1] <= r_dv_disc[j];
            end
        end
    end

    always_comb begin
        n_rp = r_dv_sp[MAG_W] ? -t_root'(r_dv_qp[MAG_W]) : t_root'(r_dv_qp[MAG_W]);
        n_rm = r_dv_sm[MAG_W] ? -t_root'(r_dv_qm[MAG_W]) : t_root'(r_dv_qm[MAG_W]);
        if (r_dv_cls[MAG_W] == CLS_NONE || r_dv_cls[MAG_W] == CLS_DEGEN) begin
            n_rp = '0;
            n_rm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_cls  <= r_dv_cls[MAG_W];
            r_o_disc <= r_dv_disc[MAG_W];
            r_o_rp   <= n_rp;
            r_o_rm   <= n_rm;
        end
    end

    assign o_root.valid        = r_v[NST-1];
    assign o_root.root_class   = r_o_cls;
    assign o_root.discriminant = r_o_disc;
    assign o_root.root_plus    = r_o_rp;
    assign o_root.root_minus   = r_o_rm;

endmodule

/* rtl/qrs_checker.sv */
module qrs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input qrs_pkg::t_root_class i_root_class,
    input qrs_pkg::t_disc       i_discriminant,
    input qrs_pkg::t_root       i_root_plus,
    input qrs_pkg::t_root       i_root_minus
);
    import qrs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_root_plus) && $stable(i_root_minus))
        else $error("result changed while stalled");

    a_no_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_root_class == CLS_NONE || i_root_class == CLS_DEGEN)
        |-> i_root_plus == '0 && i_root_minus == '0)
        else $error("roots not zero without real roots");

    a_none_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_root_class == CLS_NONE |-> i_discriminant < 0)
        else $error("no-root class with nonnegative discriminant");

    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_root_class == CLS_DOUBLE
        |-> i_discriminant == '0 && i_root_plus == i_root_minus)
        else $error("double root mismatch");

    a_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_root_class == CLS_TWO |-> i_discriminant > 0)
        else $error("two-root class with nonpositive discriminant");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_root.valid),
    .i_ready        (o_root.ready),
    .i_root_class   (o_root.root_class),
    .i_discriminant (o_root.discriminant),
    .i_root_plus    (o_root.root_plus),
    .i_root_minus   (o_root.root_minus)
);

/* sim/quadratic_root_solver_top_test.sv */
module quadratic_root_solver_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    typedef struct packed {
        t_coef a;
        t_coef b;
        t_coef c;
    } t_coef_set;

    typedef struct packed {
        t_root_class cls;
        t_disc       disc;
        t_root       rp;
        t_root       rm;
    } t_roots;

    localparam int LATENCY   = 72;
    localparam int MAX_CYCLE = 400000;

    logic i_clk;
    logic i_rst_n;

    qrs_coef_if coef_ch();
    qrs_root_if root_ch();

    quadratic_root_solver_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_ch.sink),
        .o_root  (root_ch.source)
    );

    t_coef_set pending_sets[$];
    t_roots    expected_roots[$];
    int        errors = 0;
    int        cycle = 0;
    bit        send_hold;
    bit        recv_hold;
    bit        no_idle;

    function automatic logic [63:0] floor_sqrt_scaled(logic [63:0] d);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [63:0] pair;
        root = 0;
        rem  = 0;
        for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
            pair  = (i >= FRAC_BITS) ? ((d >> (2 * (i - FRAC_BITS))) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic t_roots solve_roots(t_coef_set s);
        t_roots           r;
        longint signed    a;
        longint signed    b;
        longint signed    c;
        longint signed    d;
        longint signed    den;
        longint signed    nb;
        longint signed    sq;
        longint signed    rp;
        longint signed    rm;
        a  = s.a;
        b  = s.b;
        c  = s.c;
        d  = b * b - 4 * a * c;
        rp = 0;
        rm = 0;
        if (a == 0) begin
            r.cls = CLS_DEGEN;
        end else if (d < 0) begin
            r.cls = CLS_NONE;
        end else begin
            den = 2 * a;
            nb  = -b * (64'sd1 <<< FRAC_BITS);
            if (d == 0) begin
                r.cls = CLS_DOUBLE;
                rp    = nb / den;
                rm    = rp;
            end else begin
                sq    = floor_sqrt_scaled(d);
                r.cls = CLS_TWO;
                rp    = (nb + sq) / den;
                rm    = (nb - sq) / den;
            end
        end
        r.disc = d[DISC_W-1:0];
        r.rp   = rp[ROOT_W-1:0];
        r.rm   = rm[ROOT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    function automatic t_coef rand_coef();
        case ($urandom_range(0, 5))
            0: return t_coef'($urandom_range(0, 7)) - 16'sd4;
            1: return -16'sd32768;
            2: return 16'sd32767;
            3: return t_coef'($urandom_range(0, 255)) - 16'sd128;
            default: return t_coef'($urandom);
        endcase
    endfunction

    task automatic add_set(t_coef a, t_coef b, t_coef c);
        pending_sets.push_back('{a: a, b: b, c: c});
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE) begin
            $display("quadratic_root_solver_top_test NOT OK");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_ch.valid <= 1'b0;
        end else if (!coef_ch.valid || coef_ch.ready) begin
            if (coef_ch.valid)
                expected_roots.push_back(solve_roots('{a: coef_ch.coef_a,
                    b: coef_ch.coef_b, c: coef_ch.coef_c}));
            if (pending_sets.size() > 0 && !send_hold
                    && (no_idle || $urandom_range(0, 99) >= 34)) begin
                t_coef_set s;
                s = pending_sets.pop_front();
                coef_ch.valid  <= 1'b1;
                coef_ch.coef_a <= s.a;
                coef_ch.coef_b <= s.b;
                coef_ch.coef_c <= s.c;
            end else begin
                coef_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_ch.ready <= 1'b0;
        end else begin
            if (root_ch.valid && root_ch.ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected result", root_ch.discriminant, 0);
                end else begin
                    t_roots e;
                    e = expected_roots.pop_front();
                    if (root_ch.root_class !== e.cls)
                        report_mismatch("root_class", root_ch.root_class, e.cls);
                    if (root_ch.discriminant !== e.disc)
                        report_mismatch("discriminant", root_ch.discriminant, e.disc);
                    if (root_ch.root_plus !== e.rp)
                        report_mismatch("root_plus", root_ch.root_plus, e.rp);
                    if (root_ch.root_minus !== e.rm)
                        report_mismatch("root_minus", root_ch.root_minus, e.rm);
                end
            end
            root_ch.ready <= !recv_hold && (no_idle || $urandom_range(0, 99) >= 34);
        end
    end

    // long receiver hold-off
    initial begin
        recv_hold = 1'b0;
        repeat (150) @(posedge i_clk);
        recv_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin
        int wait_cycles;
        send_hold      = 1'b0;
        no_idle        = 1'b0;
        i_rst_n        = 1'b0;

        add_set(0, 0, 0);
        add_set(0, 5, -3);
        add_set(0, -16'sd32768, 7);
        add_set(1, -2, 1);
        add_set(1, 0, 1);
        add_set(1, 0, -1);
        add_set(2, 4, 2);
        add_set(-3, 6, -3);
        add_set(1, -3, 2);
        add_set(-1, 1, 1);
        add_set(16'sd32767, 16'sd32767, 16'sd32767);
        add_set(-16'sd32768, -16'sd32768, -16'sd32768);
        add_set(-16'sd32768, 0, 16'sd32767);
        add_set(16'sd32767, 0, -16'sd32768);
        add_set(16'sd32767, -16'sd32768, -16'sd32768);
        add_set(-16'sd32768, 16'sd32767, 16'sd32767);
        add_set(1, -16'sd32768, -16'sd32768);
        add_set(-1, 16'sd32767, 0);
        add_set(1, 16'sd32767, 0);
        add_set(16'sd32767, 1, 0);
        add_set(-16'sd1, -16'sd1, -16'sd1);
        add_set(16'sd21845, -16'sd21846, 16'sd10922);
        for (int i = 0; i < 700; i++)
            add_set(rand_coef(), rand_coef(), rand_coef());

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_sets.size() < 400);
        send_hold = 1'b1;
        wait (expected_roots.size() == 0 && !coef_ch.valid);
        repeat (LATENCY + 10) @(posedge i_clk);
        send_hold = 1'b0;

        wait (pending_sets.size() < 250);
        no_idle = 1'b1;
        wait (pending_sets.size() < 100);
        no_idle = 1'b0;

        wait (pending_sets.size() == 0 && !coef_ch.valid);
        wait_cycles = 0;
        while (expected_roots.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (expected_roots.size() != 0)
            report_mismatch("results left over", expected_roots.size(), 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("quadratic_root_solver_top_test OK");
        end else begin
            $display("quadratic_root_solver_top_test NOT OK");
        end
        $finish;
    end
endmodule
